// ----- design/smbs_pkg.sv -----
// Shared types, constants and helpers for the SPI master byte shifter.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps

package smbs_pkg;

    // Word geometry
    localparam int WORD_BITS = 8;
    localparam int IDX_W     = $clog2(WORD_BITS);
    localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(WORD_BITS - 1);

    // Configuration port geometry
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_CPOL  = 2'd0;
    localparam logic [1:0] REG_CPHA  = 2'd1;
    localparam logic [1:0] REG_LSB   = 2'd2;
    localparam logic [1:0] REG_MISO  = 2'd3;

    // Item actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BUSY    = 2'd1;
    localparam logic [1:0] STAT_IDLE    = 2'd2;

    typedef struct packed {
        logic clock_polarity;
        logic clock_phase;
        logic lsb_leads;
        logic miso_present;
    } cfg_t;

    typedef struct packed {
        logic                 action;
        logic [WORD_BITS-1:0] tx_byte;
        logic                 frame_end;
        logic                 miso_level;
    } item_t;

    typedef struct packed {
        logic                 clock_level;
        logic                 mosi_level;
        logic                 select_active;
        logic [WORD_BITS-1:0] rx_byte;
        logic                 rx_valid;
        logic                 busy_res;
        logic [1:0]           status;
    } res_t;

    // Bit of the word that goes out on the given step
    function automatic logic [IDX_W-1:0] bit_pos(input logic lsb, input logic [IDX_W-1:0] step);
        return lsb ? step : (LAST_BIT - step);
    endfunction

endpackage

// ----- design/spi_master_byte_shifter.sv -----
// Top level of the SPI master byte shifter: config port, input register, shift engine.
// Depends on smbs_pkg, smbs_cfg_regs, smbs_in_stage and smbs_engine.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    action, tx_byte, frame_end, miso_level
//   m_       out        m_valid/m_ready    clock_level, mosi_level, select_active,
//                                          rx_byte, rx_valid, busy_res, status
//   apb      in         psel/penable/pready  paddr, pwdata, prdata
//
// One item per cycle while results are taken; each result passes through the
// input register, then the result register set by the one-pass step logic.
// A held result does not block the input register, which takes one more item.
// Reset (aresetn low at a clock edge) empties both registers, idles the line and
// restores the configuration defaults.
`timescale 1ns / 1ps

module spi_master_byte_shifter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // config port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [smbs_pkg::ADDR_W-1:0]          paddr,
    input  logic [smbs_pkg::DATA_W-1:0]          pwdata,
    output logic [smbs_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    // input items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_action,
    input  logic [smbs_pkg::WORD_BITS-1:0]       s_tx_byte,
    input  logic                                 s_frame_end,
    input  logic                                 s_miso_level,
    // results
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_clock_level,
    output logic                                 m_mosi_level,
    output logic                                 m_select_active,
    output logic [smbs_pkg::WORD_BITS-1:0]       m_rx_byte,
    output logic                                 m_rx_valid,
    output logic                                 m_busy_res,
    output logic [1:0]                           m_status
);

    smbs_pkg::cfg_t  cfg;
    smbs_pkg::item_t s_item;
    smbs_pkg::item_t item;
    smbs_pkg::res_t  res;
    logic            item_valid;
    logic            item_pop;

    // Pack the input transfer
    assign s_item.action     = s_action;
    assign s_item.tx_byte    = s_tx_byte;
    assign s_item.frame_end  = s_frame_end;
    assign s_item.miso_level = s_miso_level;

    smbs_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    smbs_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    smbs_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_valid  (m_valid),
        .res_ready  (m_ready),
        .res        (res)
    );

    // Unpack the result transfer
    assign m_clock_level   = res.clock_level;
    assign m_mosi_level    = res.mosi_level;
    assign m_select_active = res.select_active;
    assign m_rx_byte       = res.rx_byte;
    assign m_rx_valid      = res.rx_valid;
    assign m_busy_res      = res.busy_res;
    assign m_status        = res.status;

endmodule

// ----- design/smbs_cfg_regs.sv -----
// Configuration registers of the SPI master byte shifter behind an APB-style port.
// Depends on smbs_pkg.
`timescale 1ns / 1ps

module smbs_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smbs_pkg::ADDR_W-1:0] paddr,
    input  logic [smbs_pkg::DATA_W-1:0] pwdata,
    output logic [smbs_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output smbs_pkg::cfg_t              cfg
);

    smbs_pkg::cfg_t cfg_reg;
    smbs_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                smbs_pkg::REG_CPOL: cfg_next.clock_polarity = pwdata[0];
                smbs_pkg::REG_CPHA: cfg_next.clock_phase    = pwdata[0];
                smbs_pkg::REG_LSB:  cfg_next.lsb_leads      = pwdata[0];
                smbs_pkg::REG_MISO: cfg_next.miso_present   = pwdata[0];
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clock_polarity <= 1'b0;
            cfg_reg.clock_phase    <= 1'b0;
            cfg_reg.lsb_leads      <= 1'b0;
            cfg_reg.miso_present   <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        case (reg_idx)
            smbs_pkg::REG_CPOL: prdata[0] = cfg_reg.clock_polarity;
            smbs_pkg::REG_CPHA: prdata[0] = cfg_reg.clock_phase;
            smbs_pkg::REG_LSB:  prdata[0] = cfg_reg.lsb_leads;
            smbs_pkg::REG_MISO: prdata[0] = cfg_reg.miso_present;
            default:            prdata    = '0;
        endcase
    end

endmodule

// ----- design/smbs_in_stage.sv -----
// Input register of the SPI master byte shifter: captures one item per transfer.
// Depends on smbs_pkg.
`timescale 1ns / 1ps

module smbs_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  smbs_pkg::item_t s_item,
    output logic            item_valid,
    output smbs_pkg::item_t item,
    input  logic            item_pop
);

    logic            valid_reg;
    logic            valid_next;
    smbs_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || item_pop;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Fill on a transfer, drop when the engine takes the item
    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- design/smbs_engine.sv -----
// Shift engine of the SPI master byte shifter: line state, one-item step logic
// and the result register. Depends on smbs_pkg.
`timescale 1ns / 1ps

module smbs_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  smbs_pkg::cfg_t  cfg,
    input  logic            item_valid,
    input  smbs_pkg::item_t item,
    output logic            item_pop,
    output logic            res_valid,
    input  logic            res_ready,
    output smbs_pkg::res_t  res
);

    localparam int WB = smbs_pkg::WORD_BITS;
    localparam int IW = smbs_pkg::IDX_W;

    // Shift state
    logic [WB-1:0] tx_shift_reg, tx_shift_next;
    logic [WB-1:0] rx_shift_reg, rx_shift_next;
    logic [IW-1:0] bit_index_reg, bit_index_next;
    logic          half_phase_reg, half_phase_next;
    logic          busy_reg, busy_next;
    logic          select_reg, select_next;
    logic          end_pending_reg, end_pending_next;
    logic          clock_reg, clock_next;
    logic          mosi_reg, mosi_next;

    // Result stage
    logic           res_valid_reg, res_valid_next;
    smbs_pkg::res_t res_reg, res_next;

    logic          advance;
    logic [IW-1:0] sample_pos;
    logic [IW-1:0] step_inc;

    assign advance   = !res_valid_reg || res_ready;
    assign item_pop  = item_valid && advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign sample_pos = smbs_pkg::bit_pos(cfg.lsb_leads, bit_index_reg);
    assign step_inc   = bit_index_reg + IW'(1);

    // Step one item
    always_comb begin
        tx_shift_next    = tx_shift_reg;
        rx_shift_next    = rx_shift_reg;
        bit_index_next   = bit_index_reg;
        half_phase_next  = half_phase_reg;
        busy_next        = busy_reg;
        select_next      = select_reg;
        end_pending_next = end_pending_reg;
        clock_next       = clock_reg;
        mosi_next        = mosi_reg;
        res_next.status  = smbs_pkg::STAT_OK;
        res_next.rx_valid = 1'b0;
        res_next.rx_byte  = '0;

        if (item.action == smbs_pkg::ACT_LOAD) begin
            if (busy_reg) begin
                res_next.status = smbs_pkg::STAT_BUSY;
            end else begin
                busy_next        = 1'b1;
                tx_shift_next    = item.tx_byte;
                rx_shift_next    = '0;
                bit_index_next   = '0;
                half_phase_next  = 1'b0;
                end_pending_next = item.frame_end;
                select_next      = 1'b1;
                clock_next       = cfg.clock_polarity;
                mosi_next = item.tx_byte[smbs_pkg::bit_pos(cfg.lsb_leads, '0)];
            end
        end else if (!busy_reg) begin
            res_next.status = smbs_pkg::STAT_IDLE;
        end else if (!half_phase_reg) begin
            // leading half: active clock level, sample in phase 0
            clock_next      = !cfg.clock_polarity;
            half_phase_next = 1'b1;
            if (!cfg.clock_phase && cfg.miso_present) begin
                rx_shift_next[sample_pos] = rx_shift_reg[sample_pos] | item.miso_level;
            end
        end else begin
            // trailing half: back to idle, sample in phase 1, then next bit or end of byte
            clock_next      = cfg.clock_polarity;
            half_phase_next = 1'b0;
            if (cfg.clock_phase && cfg.miso_present) begin
                rx_shift_next[sample_pos] = rx_shift_reg[sample_pos] | item.miso_level;
            end
            if (bit_index_reg == smbs_pkg::LAST_BIT) begin
                res_next.rx_valid = 1'b1;
                res_next.rx_byte  = rx_shift_next;
                busy_next         = 1'b0;
                bit_index_next    = '0;
                if (end_pending_reg) begin
                    select_next = 1'b0;
                end
                end_pending_next = 1'b0;
            end else begin
                bit_index_next = step_inc;
                mosi_next = tx_shift_reg[smbs_pkg::bit_pos(cfg.lsb_leads, step_inc)];
            end
        end

        res_next.clock_level   = clock_next;
        res_next.mosi_level    = mosi_next;
        res_next.select_active = select_next;
        res_next.busy_res      = busy_next;
    end

    // Result valid follows the input stage whenever the result register moves
    always_comb begin
        res_valid_next = res_valid_reg;
        if (advance) begin
            res_valid_next = item_valid;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_index_reg   <= '0;
            half_phase_reg  <= 1'b0;
            busy_reg        <= 1'b0;
            select_reg      <= 1'b0;
            end_pending_reg <= 1'b0;
            clock_reg       <= 1'b0;
            mosi_reg        <= 1'b0;
            tx_shift_reg    <= '0;
            rx_shift_reg    <= '0;
            res_valid_reg   <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (item_pop) begin
                bit_index_reg   <= bit_index_next;
                half_phase_reg  <= half_phase_next;
                busy_reg        <= busy_next;
                select_reg      <= select_next;
                end_pending_reg <= end_pending_next;
                clock_reg       <= clock_next;
                mosi_reg        <= mosi_next;
                tx_shift_reg    <= tx_shift_next;
                rx_shift_reg    <= rx_shift_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (item_pop) begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- verif/tb.sv -----
// Self-checking bench for spi_master_byte_shifter: directed byte transfers and
// random frames in all SPI modes, checked against a cycle-free model of the shifter.
// Depends on smbs_pkg and the spi_master_byte_shifter RTL.
`timescale 1ns / 1ps

module tb;
    import smbs_pkg::*;

    localparam int ITEMS_PER_PHASE = 560;
    localparam int TIMEOUT_NS      = 3_000_000;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 psel            = 1'b0;
    logic                 penable         = 1'b0;
    logic                 pwrite          = 1'b0;
    logic [ADDR_W-1:0]    paddr           = '0;
    logic [DATA_W-1:0]    pwdata          = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic                 s_action        = ACT_LOAD;
    logic [WORD_BITS-1:0] s_tx_byte       = '0;
    logic                 s_frame_end     = 1'b0;
    logic                 s_miso_level    = 1'b0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic                 m_clock_level;
    logic                 m_mosi_level;
    logic                 m_select_active;
    logic [WORD_BITS-1:0] m_rx_byte;
    logic                 m_rx_valid;
    logic                 m_busy_res;
    logic [1:0]           m_status;

    // Shifter model: line configuration and engine state, reset values
    cfg_t                 line_cfg       = cfg_t'(4'b0001);
    logic [WORD_BITS-1:0] tx_word        = '0;
    logic [WORD_BITS-1:0] rx_word        = '0;
    logic [2:0]           bit_step       = '0;
    logic                 trailing_half  = 1'b0;
    logic                 shifting       = 1'b0;
    logic                 selected       = 1'b0;
    logic                 release_at_end = 1'b0;
    logic                 sclk_q         = 1'b0;
    logic                 mosi_q         = 1'b0;

    res_t       expected_results[$];
    int         mismatches         = 0;
    int         results_seen       = 0;
    int         sender_gap_pct     = 0;
    int         receiver_stall_pct = 0;
    int         frame_left         = 0;
    logic [1:0] last_item_status   = STAT_OK;
    logic [3:0] mode_sel           = 4'd0;

    spi_master_byte_shifter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_tx_byte       (s_tx_byte),
        .s_frame_end     (s_frame_end),
        .s_miso_level    (s_miso_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_clock_level   (m_clock_level),
        .m_mosi_level    (m_mosi_level),
        .m_select_active (m_select_active),
        .m_rx_byte       (m_rx_byte),
        .m_rx_valid      (m_rx_valid),
        .m_busy_res      (m_busy_res),
        .m_status        (m_status)
    );

    initial forever #5 aclk = ~aclk;

    // Wire position of the bit handled on a given step
    function automatic logic [2:0] wire_pos(input logic [2:0] step);
        return line_cfg.lsb_leads ? step : (3'd7 - step);
    endfunction

    // Advance the shifter model by one item and return its result
    function automatic res_t shift_step(input item_t it);
        res_t r;
        r = '0;
        r.status = STAT_OK;
        if (it.action == ACT_LOAD) begin
            if (shifting) begin
                r.status = STAT_BUSY;
            end else begin
                shifting       = 1'b1;
                tx_word        = it.tx_byte;
                rx_word        = '0;
                bit_step       = '0;
                trailing_half  = 1'b0;
                release_at_end = it.frame_end;
                selected       = 1'b1;
                sclk_q         = line_cfg.clock_polarity;
                mosi_q         = tx_word[wire_pos(bit_step)];
            end
        end else if (!shifting) begin
            r.status = STAT_IDLE;
        end else if (!trailing_half) begin
            // leading half: active clock level, sample in phase 0
            sclk_q = ~line_cfg.clock_polarity;
            if (!line_cfg.clock_phase && line_cfg.miso_present)
                rx_word[wire_pos(bit_step)] = rx_word[wire_pos(bit_step)] | it.miso_level;
            trailing_half = 1'b1;
        end else begin
            // trailing half: back to idle, sample in phase 1, then next bit or finish
            sclk_q = line_cfg.clock_polarity;
            if (line_cfg.clock_phase && line_cfg.miso_present)
                rx_word[wire_pos(bit_step)] = rx_word[wire_pos(bit_step)] | it.miso_level;
            trailing_half = 1'b0;
            if (bit_step == 3'd7) begin
                r.rx_valid = 1'b1;
                r.rx_byte  = rx_word;
                shifting   = 1'b0;
                bit_step   = '0;
                if (release_at_end)
                    selected = 1'b0;
                release_at_end = 1'b0;
            end else begin
                bit_step = bit_step + 3'd1;
                mosi_q   = tx_word[wire_pos(bit_step)];
            end
        end
        r.clock_level   = sclk_q;
        r.mosi_level    = mosi_q;
        r.select_active = selected;
        r.busy_res      = shifting;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at result %0d: %s", results_seen, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Drive one item, hold it until the transfer, then record its expected result
    task automatic send_item(input logic act, input logic [7:0] tx, input logic fe,
                             input logic miso);
        item_t it;
        res_t  r;
        it = '{action: act, tx_byte: tx, frame_end: fe, miso_level: miso};
        while ($urandom_range(99) < sender_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_tx_byte    <= tx;
        s_frame_end  <= fe;
        s_miso_level <= miso;
        do @(posedge aclk); while (!s_ready);
        r = shift_step(it);
        expected_results.push_back(r);
        last_item_status = r.status;
    endtask

    // Hold the sender until every result is back, then let the pipeline settle
    task automatic quiesce_channel();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write one register, then read it back
    task automatic reg_write(input logic [1:0] idx, input logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(DATA_W-1){1'b0}}, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        psel    <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {{(DATA_W-1){1'b0}}, val})
            report_mismatch($sformatf("register %0d read %0h expected %0b", idx, prdata, val));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_mode(input cfg_t c);
        quiesce_channel();
        reg_write(REG_CPOL, c.clock_polarity);
        reg_write(REG_CPHA, c.clock_phase);
        reg_write(REG_LSB, c.lsb_leads);
        reg_write(REG_MISO, c.miso_present);
        line_cfg = c;
    endtask

    // Idle tick, refused load, first part of a byte in mode 0
    task automatic test_idle_and_refusal();
        int i;
        send_item(ACT_TICK, 8'h00, 1'b0, 1'b1);
        send_item(ACT_LOAD, 8'hFF, 1'b0, 1'b0);
        send_item(ACT_LOAD, 8'h00, 1'b1, 1'b1);
        for (i = 0; i < 7; i++)
            send_item(ACT_TICK, 8'hFF, 1'b1, i[0]);
    endtask

    // Switch every mode bit mid-byte, finish it, then load again inside the frame
    task automatic test_mid_byte_reconfig();
        int i;
        apply_mode(cfg_t'(4'b1110));
        for (i = 0; i < 9; i++)
            send_item(ACT_TICK, 8'h00, 1'b0, ~i[0]);
        send_item(ACT_LOAD, 8'h00, 1'b1, 1'b0);
        for (i = 0; i < 4; i++)
            send_item(ACT_TICK, 8'h00, 1'b0, 1'b1);
    endtask

    // Random frames of one to four bytes, with stray ticks and loads mixed in
    task automatic test_traffic(input int send_pct, input int recv_pct);
        int productive;
        int next_reconfig;
        productive    = 0;
        next_reconfig = 0;
        quiesce_channel();
        sender_gap_pct     = send_pct;
        receiver_stall_pct = recv_pct;
        while (productive < ITEMS_PER_PHASE) begin
            if (productive >= next_reconfig) begin
                apply_mode(cfg_t'(mode_sel));
                mode_sel      = mode_sel + 4'd1;
                next_reconfig = productive + $urandom_range(60, 140);
            end
            if (!shifting) begin
                if ($urandom_range(99) < 6) begin
                    send_item(ACT_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
                end else begin
                    if (frame_left == 0)
                        frame_left = $urandom_range(1, 4);
                    send_item(ACT_LOAD, 8'($urandom), frame_left == 1, 1'($urandom));
                    frame_left--;
                end
            end else if ($urandom_range(99) < 5) begin
                send_item(ACT_LOAD, 8'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                send_item(ACT_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
            end
            if (last_item_status == STAT_OK)
                productive++;
        end
    endtask

    // Compare each result transfer with the oldest expectation; randomize ready
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with none expected");
            end else begin
                want = expected_results.pop_front();
                check_field("clock_level", 8'(m_clock_level), 8'(want.clock_level));
                check_field("mosi_level", 8'(m_mosi_level), 8'(want.mosi_level));
                check_field("select_active", 8'(m_select_active), 8'(want.select_active));
                check_field("rx_byte", m_rx_byte, want.rx_byte);
                check_field("rx_valid", 8'(m_rx_valid), 8'(want.rx_valid));
                check_field("busy_res", 8'(m_busy_res), 8'(want.busy_res));
                check_field("status", 8'(m_status), 8'(want.status));
            end
            results_seen++;
        end
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    initial begin
        int spin;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sender_gap_pct     = 22;
        receiver_stall_pct = 83;
        apply_mode(cfg_t'(4'b0001));
        test_idle_and_refusal();
        test_mid_byte_reconfig();
        test_traffic(22, 83);
        test_traffic(83, 22);
        test_traffic(0, 0);
        s_valid <= 1'b0;
        spin = 0;
        while (expected_results.size() != 0 && spin < 20000) begin
            @(posedge aclk);
            spin++;
        end
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("** spi_master_byte_shifter: PASSED **");
        else
            $display("** spi_master_byte_shifter: FAILED **");
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("** spi_master_byte_shifter: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/smbs_pkg.sv
design/smbs_cfg_regs.sv
design/smbs_in_stage.sv
design/smbs_engine.sv
design/spi_master_byte_shifter.sv
verif/tb.sv
